// ===== sv/tilt_complementary_filter_assert.svh =====
// Assertion shorthands for the tilt filter checks
`ifndef TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define TCF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define TCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also covers the reset cycles
`define TCF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tcf_pkg.sv =====
`timescale 1ns / 1ps

package tcf_pkg;

   // Field and datapath widths
   localparam int SAMPLE_W   = 16;
   localparam int OUT_W      = 24;
   localparam int COEF_W     = 17;
   localparam int GAIN_W     = 16;
   localparam int ANGLE_W    = 20;
   localparam int CORDIC_W   = 34;
   localparam int SCALE_SH   = 14;
   localparam int FRAC_W     = 16;
   localparam int MULA_W     = COEF_W + 1;
   localparam int PROD_W     = MULA_W + OUT_W;
   localparam int RND_W      = PROD_W + 1 - FRAC_W;
   localparam int RATE_W     = 2 * SAMPLE_W + 1 - FRAC_W;
   localparam int CSR_ADDR_W = 2;

   // Arctangent table length and its index width
   localparam int ATAN_LEN = 24;
   localparam int IDX_W    = $clog2(ATAN_LEN);

   // pi in units of 2^-16 rad
   localparam logic signed [ANGLE_W-1:0] PI_Q16 = ANGLE_W'(205887);

   // Reset values of the configuration registers
   localparam logic [COEF_W-1:0] COEF_NEW_RST  = COEF_W'(6554);
   localparam logic [COEF_W-1:0] COEF_OLD_RST  = COEF_W'(58982);
   localparam logic [GAIN_W-1:0] GYRO_GAIN_RST = GAIN_W'(1000);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COEF_NEW  = 2'd0,
      CSR_COEF_OLD  = 2'd1,
      CSR_GYRO_GAIN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] coef_new;
      logic [COEF_W-1:0] coef_old;
      logic [GAIN_W-1:0] gyro_gain;
   } tcf_coef_type;

   typedef struct packed {
      logic start;
      logic ack;
   } tcf_ctrl_type;

   typedef struct packed {
      logic result_valid;
   } tcf_stat_type;

   // round(atan(2^-i) * 2^16)
   function automatic logic [15:0] atan_q16(input logic [IDX_W-1:0] idx);
      logic [15:0] val;
      case (idx)
         5'd0:    val = 16'd51472;
         5'd1:    val = 16'd30385;
         5'd2:    val = 16'd16055;
         5'd3:    val = 16'd8150;
         5'd4:    val = 16'd4091;
         5'd5:    val = 16'd2047;
         5'd6:    val = 16'd1024;
         5'd7:    val = 16'd512;
         5'd8:    val = 16'd256;
         5'd9:    val = 16'd128;
         5'd10:   val = 16'd64;
         5'd11:   val = 16'd32;
         5'd12:   val = 16'd16;
         5'd13:   val = 16'd8;
         5'd14:   val = 16'd4;
         5'd15:   val = 16'd2;
         5'd16:   val = 16'd1;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== sv/tcf_cordic.sv =====
`timescale 1ns / 1ps

module tcf_cordic
   import tcf_pkg::*;
#(
   parameter int ITERATIONS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SAMPLE_W-1:0] accel_x,
   input  logic signed [SAMPLE_W-1:0] accel_y,
   output logic                      done,
   output logic signed [ANGLE_W-1:0] tilt
);

   localparam int STEPS = (ITERATIONS > ATAN_LEN) ? ATAN_LEN : ITERATIONS;
   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(STEPS - 1);

   typedef enum logic {
      C_IDLE,
      C_RUN
   } cordic_state_type;

   cordic_state_type             state_ff, state_in;
   logic signed [CORDIC_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0]    z_ff, z_in;
   logic [IDX_W-1:0]             step_ff, step_in;
   logic                         zero_ff, zero_in;
   logic                         done_ff, done_in;

   logic signed [CORDIC_W-1:0]   x_sc, y_sc, dx, dy;
   logic signed [ANGLE_W-1:0]    atan_z;
   logic                         y_pos;

   // Scale the raw sample and shift by the current step
   always_comb begin
      x_sc   = CORDIC_W'(accel_x) <<< SCALE_SH;
      y_sc   = CORDIC_W'(accel_y) <<< SCALE_SH;
      dx     = x_ff >>> step_ff;
      dy     = y_ff >>> step_ff;
      atan_z = signed'(ANGLE_W'(atan_q16(step_ff)));
      y_pos  = !y_ff[CORDIC_W-1] && (y_ff != '0);
   end

   // Load the vector, then rotate it once per cycle towards the x axis
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      zero_in  = zero_ff;
      done_in  = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               zero_in  = (accel_x == '0) && (accel_y == '0);
               step_in  = '0;
               state_in = C_RUN;
               if (x_sc[CORDIC_W-1]) begin
                  x_in = -x_sc;
                  y_in = -y_sc;
                  z_in = y_sc[CORDIC_W-1] ? -PI_Q16 : PI_Q16;
               end else begin
                  x_in = x_sc;
                  y_in = y_sc;
                  z_in = '0;
               end
            end
         end
         C_RUN: begin
            if (y_pos) begin
               x_in = x_ff + dy;
               y_in = y_ff - dx;
               z_in = z_ff + atan_z;
            end else begin
               x_in = x_ff - dy;
               y_in = y_ff + dx;
               z_in = z_ff - atan_z;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = C_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   // A zero vector has no direction: report zero tilt
   assign tilt = zero_ff ? '0 : z_ff;
   assign done = done_ff;

endmodule

// ===== sv/tcf_filter.sv =====
`timescale 1ns / 1ps

module tcf_filter
   import tcf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  tcf_ctrl_type               ctrl,
   input  tcf_coef_type               coef,
   input  logic signed [ANGLE_W-1:0]  tilt,
   input  logic signed [SAMPLE_W-1:0] gyro_z,
   output tcf_stat_type               status,
   output logic signed [OUT_W-1:0]    angle
);

   localparam logic signed [PROD_W:0] ROUND_BIAS = (PROD_W + 1)'(1) << (FRAC_W - 1);

   typedef enum logic [3:0] {
      F_IDLE,
      F_RATE_MUL,
      F_RATE_RND,
      F_A_NEW,
      F_A_OLD,
      F_A_SUM,
      F_G_NEW,
      F_G_OLD,
      F_G_SUM,
      F_SUM,
      F_HOLD
   } filter_state_type;

   filter_state_type            state_ff, state_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [PROD_W-1:0]    acc_ff, acc_in;
   logic signed [RATE_W-1:0]    rate_ff, rate_in;
   logic signed [OUT_W-1:0]     accf_ff, accf_in;
   logic signed [OUT_W-1:0]     gyrof_ff, gyrof_in;
   logic signed [OUT_W-1:0]     angle_ff, angle_in;
   logic                        valid_ff, valid_in;

   logic signed [MULA_W-1:0]    mul_a;
   logic signed [OUT_W-1:0]     mul_b;
   logic signed [PROD_W:0]      addend, sum_r;
   logic signed [RND_W-1:0]     rnd, fused;

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [RND_W-1:0] v);
      logic hi_ones;
      logic hi_zeros;
      logic signed [OUT_W-1:0] res;
      hi_ones  = &v[RND_W-1:OUT_W-1];
      hi_zeros = ~|v[RND_W-1:OUT_W-1];
      if (hi_ones || hi_zeros) begin
         res = v[OUT_W-1:0];
      end else if (v[RND_W-1]) begin
         res = {1'b1, {(OUT_W - 1){1'b0}}};
      end else begin
         res = {1'b0, {(OUT_W - 1){1'b1}}};
      end
      return res;
   endfunction

   // Pick the operands of the shared multiplier
   always_comb begin
      case (state_ff)
         F_RATE_MUL: begin
            mul_a = signed'(MULA_W'(coef.gyro_gain));
            mul_b = OUT_W'(gyro_z);
         end
         F_A_NEW: begin
            mul_a = signed'(MULA_W'(coef.coef_new));
            mul_b = OUT_W'(tilt);
         end
         F_A_OLD: begin
            mul_a = signed'(MULA_W'(coef.coef_old));
            mul_b = accf_ff;
         end
         F_G_NEW: begin
            mul_a = signed'(MULA_W'(coef.coef_new));
            mul_b = OUT_W'(rate_ff);
         end
         F_G_OLD: begin
            mul_a = signed'(MULA_W'(coef.coef_old));
            mul_b = gyrof_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Round half up and drop the fraction
   always_comb begin
      addend = (state_ff == F_RATE_RND) ? '0 : (PROD_W + 1)'(acc_ff);
      sum_r  = addend + (PROD_W + 1)'(prod_ff) + ROUND_BIAS;
      rnd    = sum_r[PROD_W:FRAC_W];
      fused  = RND_W'(accf_ff) + RND_W'(gyrof_ff);
   end

   // Step through the multiplies of both filters
   always_comb begin
      state_in = state_ff;
      prod_in  = mul_a * mul_b;
      acc_in   = acc_ff;
      rate_in  = rate_ff;
      accf_in  = accf_ff;
      gyrof_in = gyrof_ff;
      angle_in = angle_ff;
      valid_in = valid_ff;
      case (state_ff)
         F_IDLE: begin
            if (ctrl.start) begin
               state_in = F_RATE_MUL;
            end
         end
         F_RATE_MUL: state_in = F_RATE_RND;
         F_RATE_RND: begin
            rate_in  = rnd[RATE_W-1:0];
            state_in = F_A_NEW;
         end
         F_A_NEW: state_in = F_A_OLD;
         F_A_OLD: begin
            acc_in   = prod_ff;
            state_in = F_A_SUM;
         end
         F_A_SUM: begin
            accf_in  = sat_out(rnd);
            state_in = F_G_NEW;
         end
         F_G_NEW: state_in = F_G_OLD;
         F_G_OLD: begin
            acc_in   = prod_ff;
            state_in = F_G_SUM;
         end
         F_G_SUM: begin
            gyrof_in = sat_out(rnd);
            state_in = F_SUM;
         end
         F_SUM: begin
            angle_in = sat_out(fused);
            valid_in = 1'b1;
            state_in = F_HOLD;
         end
         F_HOLD: begin
            if (ctrl.ack) begin
               valid_in = 1'b0;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         accf_ff  <= '0;
         gyrof_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         accf_ff  <= accf_in;
         gyrof_ff <= gyrof_in;
         valid_ff <= valid_in;
      end
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      rate_ff  <= rate_in;
      angle_ff <= angle_in;
   end

   assign status.result_valid = valid_ff;
   assign angle               = angle_ff;

endmodule

// ===== sv/tilt_complementary_filter.sv =====
`timescale 1ns / 1ps

// Tilt complementary filter. Each transfer on req_ carries one sensor sample; the block
// computes atan2(accel_y, accel_x) with a shift-add CORDIC, low-pass filters that tilt and
// the scaled gyro rate with the coefficients in the csr_ registers, and returns their
// saturated sum on rsp_ in units of 2^-16 rad, one result per sample. A sample occupies the
// block from its transfer to the earliest next one: it loads the vector, makes one
// micro-rotation per cycle on the single CORDIC shift-add unit (capped at 24 rotations),
// hands the tilt to the filter, runs nine steps on the one 18 x 24 multiplier that serves
// both filters, and moves the result into the output register. req_tready is low during
// that time, and stays low while a finished result waits for the output register to
// empty. The result waits in an output register, so a sample can be taken while the
// previous result is still pending.
// Write the csr_ registers only while the block is idle.

module tilt_complementary_filter
   import tcf_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // accel_x [15:0], accel_y [31:16], gyro_z [47:32]
   input  logic [47:0]           req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // angle [23:0]
   output logic [OUT_W-1:0]      rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [COEF_W-1:0]     csr_wdata
);

   tcf_coef_type               coef_ff, coef_in;
   logic                       busy_ff, busy_in;
   logic signed [SAMPLE_W-1:0] gyro_ff, gyro_in;
   logic [OUT_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       req_xfer;
   logic                       load_rsp;
   logic                       cordic_done;
   logic signed [ANGLE_W-1:0]  tilt;
   logic signed [OUT_W-1:0]    angle;
   tcf_ctrl_type               fctrl;
   tcf_stat_type               fstat;

   assign req_xfer = req_tvalid && !busy_ff;
   assign load_rsp = fstat.result_valid && (!rsp_valid_ff || rsp_tready);

   assign fctrl.start = cordic_done;
   assign fctrl.ack   = load_rsp;

   tcf_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (req_xfer),
      .accel_x (signed'(req_tdata[15:0])),
      .accel_y (signed'(req_tdata[31:16])),
      .done    (cordic_done),
      .tilt    (tilt)
   );

   tcf_filter u_filter (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (fctrl),
      .coef   (coef_ff),
      .tilt   (tilt),
      .gyro_z (gyro_ff),
      .status (fstat),
      .angle  (angle)
   );

   // Register writes
   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_COEF_NEW:  coef_in.coef_new  = csr_wdata;
            CSR_COEF_OLD:  coef_in.coef_old  = csr_wdata;
            CSR_GYRO_GAIN: coef_in.gyro_gain = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Hold the gyro sample, track the busy window and drive the output register
   always_comb begin
      busy_in      = busy_ff;
      gyro_in      = gyro_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
         gyro_in = signed'(req_tdata[47:32]);
      end
      if (load_rsp) begin
         busy_in      = 1'b0;
         rsp_data_in  = angle;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.coef_new  <= COEF_NEW_RST;
         coef_ff.coef_old  <= COEF_OLD_RST;
         coef_ff.gyro_gain <= GYRO_GAIN_RST;
         busy_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gyro_ff     <= gyro_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/tcf_checker.sv =====
`timescale 1ns / 1ps

`include "tilt_complementary_filter_assert.svh"

module tcf_checker
   import tcf_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [OUT_W-1:0] rsp_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready
);

   // A pending result stays put until taken
   `TCF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")

   // One sample at a time: no transfer right after a transfer
   `TCF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "req_tready high right after a sample transfer")

   // A fresh result only ends a busy window
   `TCF_ASSERT_IMPLY(a_rsp_after_busy, clock, reset, $rose(rsp_tvalid), $past(!req_tready), "result appeared without a sample in work")

   // Reset leaves the block idle with no result
   `TCF_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid && req_tready, "block not idle after reset")

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (.*);
